FILE: src/tsr_pkg.sv
// Shared types and constants for the PES timestamp rebase block.
package tsr_pkg;

    // Header window geometry
    localparam int WIN_LEN = 19;
    localparam int POS_W   = 5;
    localparam int STAMP_W = 33;
    localparam int PTS_POS = 9;
    localparam int DTS_POS = 14;
    localparam int FIELD_BYTES = 5;

    // Byte 7 flag bits and re-encode prefixes
    localparam logic [7:0] FLAG_PTS       = 8'h80;
    localparam logic [7:0] FLAG_DTS       = 8'h40;
    localparam logic [7:0] PREFIX_PTS     = 8'h21;
    localparam logic [7:0] PREFIX_PTS_DTS = 8'h31;
    localparam logic [7:0] PREFIX_DTS     = 8'h11;

    // Start code bytes
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [STAMP_W-1:0]       t_stamp;
    typedef logic [8*FIELD_BYTES-1:0] t_field;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       header_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       window_last;
    } t_out_item;

    // Which timestamp fields get replaced on emit
    typedef struct packed {
        logic pts_rw;
        logic dts_rw;
    } t_rw_ctl;

endpackage

FILE: src/pes_timestamp_rebase.sv
// Top level: PES header window buffering, timestamp rewrite and byte output.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready   | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_data (33-bit offset)
//
//  Pass-through and window fill bytes are accepted back to back unless the
//  output stalls. A completed window is scanned from the buffer RAM, passed
//  through the timestamp unit, then emitted with a read and an output step
//  per byte, paced by the single registered RAM read port. An aborted window
//  flushes with a read and an output step per buffered byte. Input is held
//  off while a window is processed. Reset is synchronous; the buffer RAM
//  needs no clearing. Output stalls hold the output register and output states.
module pes_timestamp_rebase (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tsr_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tsr_pkg::t_out_item   o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  tsr_pkg::t_stamp      i_cfg_data
);
    import tsr_pkg::*;

    typedef enum logic [2:0] {
        S_RUN,
        S_FLUSH_RD,
        S_FLUSH_OUT,
        S_SCAN,
        S_CALC,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state     r_state, n_state;
    t_pos       r_pos, n_pos;
    t_pos       r_addr, n_addr;
    logic [7:0] r_pend, n_pend;
    t_stamp     r_offset;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_item, n_out_item;

    // Scan capture
    logic       r_scan_vld;
    t_pos       r_scan_addr;
    logic [7:0] r_b0, r_b1, r_b2, r_flags;
    t_field     r_pts_f, r_dts_f;

    // RAM and timestamp unit signals
    logic       wr_en, rd_en;
    t_pos       wr_addr, rd_addr;
    logic [7:0] wr_data, rd_data;
    logic       stamp_go;
    t_rw_ctl    rw_ctl;
    t_field     new_pts, new_dts;

    logic       out_free, in_acc;
    logic [7:0] emit_byte;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_RUN) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    tsr_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tsr_stamp u_stamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (stamp_go),
        .i_offset    (r_offset),
        .i_hdr_ok    ((r_b0 == SC_ZERO) && (r_b1 == SC_ZERO) && (r_b2 == SC_ONE)),
        .i_flags     (r_flags),
        .i_pts_field (r_pts_f),
        .i_dts_field (r_dts_f),
        .o_ctl       (rw_ctl),
        .o_pts_field (new_pts),
        .o_dts_field (new_dts)
    );

    // Substitute rewritten timestamp bytes on emit
    always_comb begin
        emit_byte = rd_data;
        for (int k = 0; k < FIELD_BYTES; k++) begin
            if (rw_ctl.pts_rw && (r_addr == t_pos'(PTS_POS + k))) begin
                emit_byte = new_pts[8*(FIELD_BYTES-1-k) +: 8];
            end
            if (rw_ctl.dts_rw && (r_addr == t_pos'(DTS_POS + k))) begin
                emit_byte = new_dts[8*(FIELD_BYTES-1-k) +: 8];
            end
        end
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = i_in_item.data_byte;
        rd_en       = 1'b0;
        rd_addr     = r_addr;
        stamp_go    = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (in_acc) begin
                    if (i_in_item.header_start) begin
                        if ((r_pos != t_pos'(WIN_LEN)) && (r_pos != '0)) begin
                            // Abort the open window: flush it, hold the new byte
                            n_pend  = i_in_item.data_byte;
                            n_addr  = '0;
                            n_state = S_FLUSH_RD;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            n_pos   = t_pos'(1);
                        end
                    end else if (r_pos == t_pos'(WIN_LEN)) begin
                        // Pass through
                        n_out_valid = 1'b1;
                        n_out_item  = '{out_byte: i_in_item.data_byte, window_last: 1'b0};
                    end else begin
                        // Fill the window
                        wr_en = 1'b1;
                        n_pos = r_pos + t_pos'(1);
                        if (r_pos == t_pos'(WIN_LEN - 1)) begin
                            n_addr  = '0;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_FLUSH_RD: begin
                rd_en   = 1'b1;
                n_state = S_FLUSH_OUT;
            end
            S_FLUSH_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{out_byte: rd_data, window_last: 1'b0};
                    if (r_addr == (r_pos - t_pos'(1))) begin
                        // Open the new window with the held byte
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = r_pend;
                        n_pos   = t_pos'(1);
                        n_state = S_RUN;
                    end else begin
                        n_addr  = r_addr + t_pos'(1);
                        n_state = S_FLUSH_RD;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == t_pos'(WIN_LEN)) begin
                    n_state = S_CALC;
                end else begin
                    rd_en  = 1'b1;
                    n_addr = r_addr + t_pos'(1);
                end
            end
            S_CALC: begin
                stamp_go = 1'b1;
                n_addr   = '0;
                n_state  = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                rd_en   = 1'b1;
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{out_byte:    emit_byte,
                                    window_last: (r_addr == t_pos'(WIN_LEN - 1))};
                    if (r_addr == t_pos'(WIN_LEN - 1)) begin
                        n_pos   = t_pos'(WIN_LEN);
                        n_state = S_RUN;
                    end else begin
                        n_addr  = r_addr + t_pos'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // State, counters and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_pos       <= t_pos'(WIN_LEN);
            r_addr      <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
            r_scan_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_out_item  <= n_out_item;
            r_scan_vld  <= (r_state == S_SCAN) && rd_en;
            r_scan_addr <= r_addr;
            if (i_cfg_valid) begin
                r_offset <= i_cfg_data;
            end
        end
    end

    // Capture header fields as scan reads return
    always_ff @(posedge i_clk) begin
        if (r_scan_vld) begin
            if (r_scan_addr == t_pos'(0)) r_b0 <= rd_data;
            if (r_scan_addr == t_pos'(1)) r_b1 <= rd_data;
            if (r_scan_addr == t_pos'(2)) r_b2 <= rd_data;
            if (r_scan_addr == t_pos'(7)) r_flags <= rd_data;
            for (int k = 0; k < FIELD_BYTES; k++) begin
                if (r_scan_addr == t_pos'(PTS_POS + k)) begin
                    r_pts_f[8*(FIELD_BYTES-1-k) +: 8] <= rd_data;
                end
                if (r_scan_addr == t_pos'(DTS_POS + k)) begin
                    r_dts_f[8*(FIELD_BYTES-1-k) +: 8] <= rd_data;
                end
            end
        end
    end

    // Position never runs past the window length
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= t_pos'(WIN_LEN))
        else $error("window position out of range");

    // The buffer is not written while a window is scanned or emitted
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_CALC || r_state == S_EMIT_RD ||
         r_state == S_EMIT_OUT) |-> !wr_en)
        else $error("buffer written during window processing");

    // The last window byte starts the scan
    a_fill_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_item.header_start && r_pos == t_pos'(WIN_LEN - 1))
        |=> r_state == S_SCAN)
        else $error("completed window did not start scan");

    // Window-last marks only the final emitted byte of a window
    a_last_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && n_out_item.window_last && out_free) |->
        (r_state == S_EMIT_OUT && r_addr == t_pos'(WIN_LEN - 1)))
        else $error("window_last outside window emit");

    // Timestamp unit runs once, right before emit
    a_calc_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CALC |=> r_state == S_EMIT_RD)
        else $error("calc not followed by emit");

endmodule

FILE: src/tsr_ram.sv
// Header window buffer: one write port, one read port, registered read data.
module tsr_ram (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  tsr_pkg::t_pos     i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  tsr_pkg::t_pos     i_rd_addr,
    output logic [7:0]        o_rd_data
);
    import tsr_pkg::*;

    logic [7:0] mem [WIN_LEN];
    logic [7:0] r_rd_data;

    // Write the incoming byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold data when idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/tsr_stamp.sv
// Timestamp unit: decode PTS/DTS, subtract the offset with saturation, re-encode.
module tsr_stamp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  tsr_pkg::t_stamp     i_offset,
    input  logic                i_hdr_ok,
    input  logic [7:0]          i_flags,
    input  tsr_pkg::t_field     i_pts_field,
    input  tsr_pkg::t_field     i_dts_field,
    output tsr_pkg::t_rw_ctl    o_ctl,
    output tsr_pkg::t_field     o_pts_field,
    output tsr_pkg::t_field     o_dts_field
);
    import tsr_pkg::*;

    function automatic t_stamp unpack_stamp(input t_field f);
        unpack_stamp = {f[35:33], f[31:24], f[23:17], f[15:8], f[7:1]};
    endfunction

    function automatic t_field pack_stamp(input t_stamp v, input logic [7:0] prefix);
        logic [7:0] b0;
        b0 = {4'b0000, v[32:30], 1'b0} + prefix;
        pack_stamp = {b0, v[29:22], v[21:15], 1'b1, v[14:7], v[6:0], 1'b1};
    endfunction

    function automatic t_stamp rebase(input t_stamp v, input t_stamp off);
        logic [STAMP_W:0] diff;
        diff = {1'b0, v} - {1'b0, off};
        rebase = diff[STAMP_W] ? '0 : diff[STAMP_W-1:0];
    endfunction

    t_stamp     pts, dts;
    logic       pts_nz, dts_nz;
    logic [7:0] pts_prefix;

    // Decode only stamps whose flag is set under a valid start code
    always_comb begin
        pts        = (i_hdr_ok && ((i_flags & FLAG_PTS) != '0)) ? unpack_stamp(i_pts_field) : '0;
        dts        = (i_hdr_ok && ((i_flags & FLAG_DTS) != '0)) ? unpack_stamp(i_dts_field) : '0;
        pts_nz     = (pts != '0);
        dts_nz     = (dts != '0);
        pts_prefix = dts_nz ? PREFIX_PTS_DTS : PREFIX_PTS;
    end

    // Register the rewrite decision and the new fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_go) begin
            o_ctl.pts_rw <= pts_nz;
            o_ctl.dts_rw <= dts_nz;
            o_pts_field  <= pack_stamp(rebase(pts, i_offset), pts_prefix);
            o_dts_field  <= pack_stamp(rebase(dts, i_offset), PREFIX_DTS);
        end
    end

endmodule
